### src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/slcfr_pkg.sv
// Package: constants, types and the CRC byte function of the frame receiver.
package slcfr_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam logic [7:0] SYNC_A = 8'hA5;
    localparam logic [7:0] SYNC_B = 8'h5A;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP = 16'h8000;
    localparam logic [7:0] HDR_TRL_LEN = 8'd5;
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_B0,
        S_B1,
        S_B2,
        S_CRC,
        S_CH,
        S_CL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       clear;
        logic       append;
        logic       drop_one;
        logic       drop_frame;
        logic       crc_first;
        logic       crc_step;
        logic       crc_hi_load;
        logic       out_load;
        logic       out_last;
        logic [7:0] rd_off;
        logic [7:0] idx;
        logic [7:0] len;
    } t_dp_cmd;

    typedef struct packed {
        logic [7:0] rd_data;
        logic       fill_lt2;
        logic       fill_lt3;
        logic       fill_short;
        logic       crc_ok;
        logic       out_busy;
    } t_dp_status;

    // One byte of CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### src/slcfr_in_if.sv
// Input channel: command and received byte with valid/ready.
interface slcfr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;
    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

// Output channel: payload bytes of validated frames with valid/ready.
interface slcfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic [6:0] frame_length;
    logic       last;
    modport source (output valid, output payload_byte, output byte_index,
                    output frame_length, output last, input ready);
    modport sink (input valid, input payload_byte, input byte_index,
                  input frame_length, input last, output ready);
endinterface

### src/sync_length_crc_frame_receiver.sv
// Sequence: after an accepted byte the controller scans for sync A and B, checks the length,
// runs the CRC over length and payload, compares the CRC bytes and then emits the payload;
// any mismatch drops one byte and rescans.
// Throughput: one payload byte per cycle while the sink is ready; the next input is taken once
// scan and emission settle.
// Reset: synchronous, active low; empties the buffer and idles the controller and output.
`include "assert_macros.svh"
module sync_length_crc_frame_receiver #(
    parameter int MAX_PAYLOAD = slcfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slcfr_in_if.sink      i_in,
    slcfr_out_if.source   o_out
);

    slcfr_pkg::t_dp_cmd    dp_cmd;
    slcfr_pkg::t_dp_status dp_status;
    logic                  in_ready;

    // Controller: walks the buffer front for sync, length and CRC, then streams payload.
    slcfr_ctrl #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Datapath: circular buffer with one registered read per cycle, CRC and output register.
    slcfr_dp #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_in.rx_byte),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_payload_byte (o_out.payload_byte),
        .o_byte_index   (o_out.byte_index),
        .o_frame_length (o_out.frame_length),
        .o_last         (o_out.last)
    );

    assign i_in.ready = in_ready;

    // A transaction is taken only when the controller can start a new append or clear.
    `ASSERT_NEXT(a_take_moves_on, i_clk, i_rst_n, i_in.valid && in_ready && i_in.cmd == slcfr_pkg::CMD_APPEND, !in_ready)
    `ASSERT_ALWAYS(a_one_action, i_clk, i_rst_n, !(dp_cmd.append && (dp_cmd.drop_one || dp_cmd.drop_frame)))
    `ASSERT_ALWAYS(a_frame_end, i_clk, i_rst_n, !dp_cmd.drop_frame || (dp_cmd.out_load && dp_cmd.out_last))

endmodule

### src/slcfr_ctrl.sv
// Controller: sequences append, frame scan, CRC check and payload emission.
module slcfr_ctrl #(
    parameter int MAX_PAYLOAD = slcfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_cmd,
    output logic                   o_in_ready,
    input  slcfr_pkg::t_dp_status  i_status,
    output slcfr_pkg::t_dp_cmd     o_cmd
);

    slcfr_pkg::t_state r_state, n_state;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_len, n_len;
    logic [7:0] data;

    assign data = i_status.rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slcfr_pkg::S_IDLE;
            r_pos   <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_len   <= n_len;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_len      = r_len;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_off = r_pos;
        o_cmd.len    = r_len;
        o_cmd.idx    = r_pos;
        case (r_state)
            slcfr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == slcfr_pkg::CMD_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.append = 1'b1;
                        n_state = slcfr_pkg::S_SCAN;
                    end
                end
            end
            slcfr_pkg::S_SCAN: begin
                o_cmd.rd_off = 8'd0;
                n_state = i_status.fill_lt2 ? slcfr_pkg::S_IDLE : slcfr_pkg::S_B0;
            end
            slcfr_pkg::S_B0: begin
                if (data != slcfr_pkg::SYNC_A) begin
                    o_cmd.drop_one = 1'b1;
                    n_state = slcfr_pkg::S_SCAN;
                end else begin
                    o_cmd.rd_off = 8'd1;
                    n_state = slcfr_pkg::S_B1;
                end
            end
            slcfr_pkg::S_B1: begin
                if (data != slcfr_pkg::SYNC_B) begin
                    o_cmd.drop_one = 1'b1;
                    n_state = slcfr_pkg::S_SCAN;
                end else if (i_status.fill_lt3) begin
                    n_state = slcfr_pkg::S_IDLE;
                end else begin
                    o_cmd.rd_off = 8'd2;
                    n_state = slcfr_pkg::S_B2;
                end
            end
            slcfr_pkg::S_B2: begin
                if (data == 8'd0 || data > 8'(MAX_PAYLOAD)) begin
                    o_cmd.drop_one = 1'b1;
                    n_state = slcfr_pkg::S_SCAN;
                end else if (i_status.fill_short) begin
                    n_state = slcfr_pkg::S_IDLE;
                end else begin
                    n_len = data;
                    o_cmd.crc_first = 1'b1;
                    o_cmd.rd_off = 8'd3;
                    n_pos = 8'd3;
                    n_state = slcfr_pkg::S_CRC;
                end
            end
            slcfr_pkg::S_CRC: begin
                o_cmd.crc_step = 1'b1;
                if (r_pos == r_len + 8'd2) begin
                    o_cmd.rd_off = r_len + 8'd3;
                    n_state = slcfr_pkg::S_CH;
                end else begin
                    n_pos = r_pos + 8'd1;
                    o_cmd.rd_off = r_pos + 8'd1;
                end
            end
            slcfr_pkg::S_CH: begin
                o_cmd.crc_hi_load = 1'b1;
                o_cmd.rd_off = r_len + 8'd4;
                n_state = slcfr_pkg::S_CL;
            end
            slcfr_pkg::S_CL: begin
                if (!i_status.crc_ok) begin
                    o_cmd.drop_one = 1'b1;
                    n_state = slcfr_pkg::S_SCAN;
                end else begin
                    n_pos = 8'd0;
                    o_cmd.rd_off = 8'd3;
                    n_state = slcfr_pkg::S_EMIT;
                end
            end
            slcfr_pkg::S_EMIT: begin
                o_cmd.rd_off = r_pos + 8'd3;
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_pos == r_len - 8'd1);
                    if (r_pos == r_len - 8'd1) begin
                        o_cmd.drop_frame = 1'b1;
                        n_state = slcfr_pkg::S_IDLE;
                    end else begin
                        n_pos = r_pos + 8'd1;
                        o_cmd.rd_off = r_pos + 8'd4;
                    end
                end
            end
            default: begin
                n_state = slcfr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### src/slcfr_dp.sv
// Datapath: circular byte buffer, CRC register and output register.
`include "assert_macros.svh"
module slcfr_dp #(
    parameter int MAX_PAYLOAD = slcfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_rx_byte,
    input  slcfr_pkg::t_dp_cmd     i_cmd,
    output slcfr_pkg::t_dp_status  o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [7:0]             o_payload_byte,
    output logic [5:0]             o_byte_index,
    output logic [6:0]             o_frame_length,
    output logic                   o_last
);

    localparam int DEPTH = MAX_PAYLOAD + 5;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_rd_data;
    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [15:0]      r_crc;
    logic [7:0]       r_hi;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [5:0]       r_out_idx;
    logic [6:0]       r_out_len;
    logic             r_out_last;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] wr_addr;
    logic [8:0]       drop_k;

    // Wrap head plus an offset of at most the depth back into the buffer.
    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] base,
                                              input logic [8:0] off);
        logic [9:0] s;
        s = {{(10-PTR_W){1'b0}}, base} + {1'b0, off};
        if (s >= 10'(DEPTH)) begin
            s = s - 10'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    assign rd_addr = wrap(r_head, {1'b0, i_cmd.rd_off});
    assign wr_addr = wrap(r_head, 9'(r_fill));
    assign drop_k  = i_cmd.drop_frame ? ({1'b0, i_cmd.len} + 9'(slcfr_pkg::HDR_TRL_LEN))
                                      : 9'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && r_fill < CNT_W'(DEPTH)) begin
            r_mem[wr_addr] <= i_rx_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_cmd.clear) begin
            n_fill = '0;
        end else if (i_cmd.append) begin
            if (r_fill < CNT_W'(DEPTH)) begin
                n_fill = r_fill + CNT_W'(1);
            end
        end else if (i_cmd.drop_one || i_cmd.drop_frame) begin
            n_head = wrap(r_head, drop_k);
            n_fill = r_fill - drop_k[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.crc_first) begin
            r_crc <= slcfr_pkg::crc_byte(slcfr_pkg::CRC_INIT, r_rd_data);
        end else if (i_cmd.crc_step) begin
            r_crc <= slcfr_pkg::crc_byte(r_crc, r_rd_data);
        end
        if (i_cmd.crc_hi_load) begin
            r_hi <= r_rd_data;
        end
        if (i_cmd.out_load) begin
            r_out_byte <= r_rd_data;
            r_out_idx  <= i_cmd.idx[5:0];
            r_out_len  <= i_cmd.len[6:0];
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_status.rd_data    = r_rd_data;
    assign o_status.fill_lt2   = (r_fill < CNT_W'(2));
    assign o_status.fill_lt3   = (r_fill < CNT_W'(3));
    assign o_status.fill_short = ({{(9-CNT_W){1'b0}}, r_fill}
                                  < ({1'b0, r_rd_data} + 9'(slcfr_pkg::HDR_TRL_LEN)));
    assign o_status.crc_ok     = ({r_hi, r_rd_data} == r_crc);
    assign o_status.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_byte_index   = r_out_idx;
    assign o_frame_length = r_out_len;
    assign o_last         = r_out_last;

    `ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= CNT_W'(DEPTH))
    `ASSERT_ALWAYS(a_head_bound, i_clk, i_rst_n, r_head < PTR_W'(DEPTH))
    `ASSERT_NEXT(a_append_grows, i_clk, i_rst_n, i_cmd.append && r_fill < CNT_W'(DEPTH), r_fill == $past(r_fill) + CNT_W'(1))
    `ASSERT_NEXT(a_load_when_free, i_clk, i_rst_n, i_cmd.out_load, r_out_valid)

endmodule
